// ===== rtl/bitsliced_discrete_gaussian_sampler_assert.svh =====
// assertion macros shared by the sampler modules
`ifndef BITSLICED_DISCRETE_GAUSSIAN_SAMPLER_ASSERT_SVH
`define BITSLICED_DISCRETE_GAUSSIAN_SAMPLER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define DGS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define DGS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/dgs_pkg.sv =====
// shared types, constants and formula sets of the discrete gaussian sampler
package dgs_pkg;

	localparam int LANES        = 64;
	localparam int LANE_W       = 6;
	localparam int STORE_DEPTH  = 12;
	localparam int CNT_W        = 4;
	localparam int POLY_LEN_DEF = 256;
	localparam int QUEUE_DEPTH  = 2;
	localparam int CFG_AW       = 2;
	localparam int CFG_DW       = 4;
	localparam logic [3:0] SHIFT_RESET = 4'd6;

	localparam logic [CFG_AW-1:0] REG_NOISE_VARIANT = 2'd0;
	localparam logic [CFG_AW-1:0] REG_COEFF_SHIFT   = 2'd1;

	typedef enum logic [1:0] {
		NV_D1 = 2'd0,
		NV_D2 = 2'd1,
		NV_D3 = 2'd2,
		NV_D4 = 2'd3
	} variant_t;

	typedef logic [63:0] word_t;
	typedef word_t [STORE_DEPTH-1:0] store_t;
	typedef word_t [3:0] mag_t;

	typedef struct packed {
		mag_t       mag;
		word_t      sign;
		logic [3:0] shift;
		logic [1:0] grp;
		logic       poly_last;
	} grp_rec_t;

	function automatic logic [CNT_W-1:0] group_size(input variant_t v);
		logic [CNT_W-1:0] s;
		unique case (v)
			NV_D1:   s = 4'd10;
			NV_D2:   s = 4'd11;
			NV_D3:   s = 4'd12;
			NV_D4:   s = 4'd11;
			default: s = 4'd11;
		endcase
		return s;
	endfunction

	function automatic mag_t mag_eval(input variant_t v, input store_t a);
		store_t b;
		mag_t   m;
		b = ~a;
		m = '0;
		unique case (v)
			NV_D1: begin
				m[0] = (a[0] & a[1] & a[2] & a[3] & a[4] & a[5] & a[7] & b[8]) |
				       (a[0] & a[3] & a[4] & a[5] & a[6] & a[8]) |
				       (a[1] & a[3] & a[4] & a[5] & a[6] & a[8]) |
				       (a[2] & a[3] & a[4] & a[5] & a[6] & a[8]) |
				       (b[2] & b[3] & b[6] & a[8]) | (b[1] & b[3] & b[6] & a[8]) |
				       (a[6] & a[7] & b[8]) | (b[5] & b[6] & a[8]) |
				       (b[4] & b[6] & a[8]) | (b[7] & a[8]);
				m[1] = (a[1] & a[2] & a[4] & a[5] & a[7] & a[8]) |
				       (a[3] & a[4] & a[5] & a[7] & a[8]) | (a[6] & a[7] & a[8]);
			end
			NV_D2: begin
				m[0] = (a[0] & a[1] & a[2] & a[3] & a[5] & a[7] & a[8]) |
				       (a[1] & a[2] & a[3] & a[5] & b[6] & a[7] & a[9]) |
				       (b[1] & b[2] & b[3] & a[6] & a[7] & a[8]) |
				       (b[1] & b[2] & b[3] & b[5] & b[8] & a[9]) |
				       (b[0] & b[2] & b[3] & b[5] & b[8] & a[9]) |
				       (a[4] & a[5] & b[6] & a[7] & a[9]) |
				       (a[3] & a[4] & a[8] & b[9]) | (b[5] & a[6] & a[7] & a[8]) |
				       (b[4] & a[6] & a[7] & a[8]) | (b[4] & b[5] & b[8] & a[9]) |
				       (a[5] & a[8] & b[9]) | (a[6] & a[8] & b[9]) |
				       (a[7] & a[8] & b[9]) | (b[7] & b[8] & a[9]) |
				       (b[6] & b[8] & a[9]);
				m[1] = (a[0] & a[1] & a[4] & b[5] & a[6] & a[7] & a[9]) |
				       (a[2] & a[4] & b[5] & a[6] & a[7] & a[9]) |
				       (a[3] & a[4] & b[5] & a[6] & a[7] & a[9]) |
				       (a[5] & a[6] & a[7] & b[8] & a[9]) |
				       (b[1] & b[2] & b[3] & a[8] & a[9]) | (b[7] & a[8] & a[9]) |
				       (b[6] & a[8] & a[9]) | (b[5] & a[8] & a[9]) |
				       (b[4] & a[8] & a[9]);
				m[2] = (a[1] & a[4] & a[5] & a[6] & a[7] & a[8] & a[9]) |
				       (a[2] & a[4] & a[5] & a[6] & a[7] & a[8] & a[9]) |
				       (a[3] & a[4] & a[5] & a[6] & a[7] & a[8] & a[9]);
			end
			NV_D3: begin
				m[0] = (a[0] & b[2] & b[3] & a[4] & a[6] & a[7] & a[9]) |
				       (a[1] & b[2] & b[3] & a[4] & a[6] & a[7] & a[9]) |
				       (b[0] & b[1] & b[3] & a[5] & a[6] & a[7] & a[9]) |
				       (a[1] & a[2] & a[3] & a[5] & a[6] & a[7] & a[9]) |
				       (b[1] & b[2] & b[3] & b[4] & b[7] & a[8] & a[9]) |
				       (a[2] & a[4] & b[5] & a[6] & a[8] & a[9]) |
				       (b[3] & b[4] & b[7] & b[8] & b[9] & a[10]) |
				       (a[3] & a[4] & a[7] & a[8] & b[10]) |
				       (a[3] & a[4] & b[5] & a[6] & a[9]) |
				       (b[4] & a[5] & a[6] & a[7] & a[9]) |
				       (b[6] & b[7] & b[8] & b[9] & a[10]) |
				       (b[5] & b[7] & b[8] & b[9] & a[10]) |
				       (a[5] & a[7] & a[8] & b[10]) | (a[6] & a[7] & a[8] & b[10]) |
				       (a[5] & a[6] & b[8] & a[9]) | (b[6] & b[7] & a[8] & a[9]) |
				       (b[5] & b[7] & a[8] & a[9]) | (a[7] & b[8] & a[9]) |
				       (a[9] & b[10]);
				m[1] = (a[0] & a[2] & a[4] & a[5] & a[6] & a[7] & a[10]) |
				       (a[1] & a[2] & a[4] & a[5] & a[6] & a[7] & a[10]) |
				       (b[1] & b[2] & b[3] & b[4] & b[7] & a[9] & a[10]) |
				       (a[3] & a[4] & a[5] & a[6] & a[7] & a[10]) |
				       (a[3] & a[5] & a[6] & b[8] & a[10]) |
				       (a[4] & a[5] & a[6] & b[8] & a[10]) |
				       (b[6] & b[7] & a[9] & a[10]) | (b[5] & b[7] & a[9] & a[10]) |
				       (a[7] & b[8] & a[10]) | (a[8] & b[9] & a[10]) |
				       (b[8] & a[9] & a[10]);
				m[2] = (a[1] & a[5] & a[6] & a[8] & a[9] & a[10]) |
				       (a[2] & a[5] & a[6] & a[8] & a[9] & a[10]) |
				       (a[3] & a[5] & a[6] & a[8] & a[9] & a[10]) |
				       (a[4] & a[5] & a[6] & a[8] & a[9] & a[10]) |
				       (a[7] & a[8] & a[9] & a[10]);
			end
			NV_D4: begin
				m[0] = (a[0] & a[1] & b[2] & a[3] & a[4] & b[6] & a[7] & b[9]) |
				       (a[2] & a[3] & a[4] & b[5] & b[6] & a[7] & b[9]) |
				       (b[2] & b[3] & b[4] & b[5] & b[7] & a[8]) |
				       (b[1] & b[3] & b[4] & b[5] & b[7] & a[8]) |
				       (b[0] & b[3] & b[4] & b[5] & b[7] & a[8]) |
				       (a[0] & b[2] & a[3] & a[5] & b[6] & a[8]) |
				       (a[1] & b[2] & a[3] & a[5] & b[6] & a[8]) |
				       (a[2] & a[3] & b[4] & a[5] & b[6] & a[8]) |
				       (a[0] & a[1] & a[4] & a[5] & a[7] & a[9]) |
				       (a[2] & b[3] & a[4] & a[6] & a[7] & a[9]) |
				       (b[2] & a[3] & a[4] & a[6] & a[7] & a[9]) |
				       (b[3] & a[5] & b[6] & a[7] & b[9]) |
				       (a[0] & a[2] & a[5] & a[7] & b[8]) |
				       (a[1] & a[2] & a[5] & a[7] & b[8]) |
				       (a[4] & a[5] & b[6] & a[7] & a[9]) |
				       (b[4] & b[5] & a[6] & a[7] & a[9]) |
				       (b[2] & b[5] & a[6] & a[7] & a[9]) |
				       (a[3] & a[5] & a[7] & b[8]) | (b[5] & b[6] & a[8] & b[9]) |
				       (b[2] & b[6] & a[8] & b[9]) | (a[6] & a[7] & b[8]) |
				       (b[7] & a[8] & b[9]) | (b[6] & b[7] & a[8]);
				m[1] = (a[2] & a[3] & a[4] & a[5] & a[7] & a[8] & b[9]) |
				       (a[2] & a[3] & a[4] & b[5] & a[6] & a[7] & a[9]) |
				       (b[2] & b[3] & b[4] & b[5] & b[7] & a[9]) |
				       (b[1] & b[3] & b[4] & b[5] & b[7] & a[9]) |
				       (b[0] & b[3] & b[4] & b[5] & b[7] & a[9]) |
				       (b[4] & a[5] & a[6] & a[7] & a[9]) |
				       (b[3] & a[5] & a[6] & a[7] & a[9]) |
				       (b[2] & a[5] & a[6] & a[7] & a[9]) |
				       (a[6] & a[7] & a[8] & b[9]) | (b[6] & b[7] & a[9]) |
				       (b[8] & a[9]);
				m[2] = (a[0] & a[1] & a[2] & b[3] & a[6] & a[8] & a[9]) |
				       (a[3] & a[6] & b[7] & a[8] & a[9]) |
				       (a[4] & b[5] & a[6] & a[8] & a[9]) |
				       (b[3] & a[5] & a[6] & a[8] & a[9]) |
				       (b[6] & a[7] & a[8] & a[9]) | (b[4] & a[7] & a[8] & a[9]) |
				       (b[2] & a[7] & a[8] & a[9]);
				m[3] = (a[2] & a[3] & a[4] & a[5] & a[6] & a[7] & a[8] & a[9]);
			end
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/dgs_front.sv =====
// front end: word store, config registers, group completion and formula evaluation
module dgs_front #(
	parameter int POLY_LEN = dgs_pkg::POLY_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [63:0]                 s_tdata,
	input  logic                        cfg_we,
	input  logic [dgs_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [dgs_pkg::CFG_DW-1:0]  cfg_wdata,
	input  logic                        q_full,
	output logic                        q_push,
	output dgs_pkg::grp_rec_t           q_data
);

	localparam int GROUPS = (POLY_LEN / dgs_pkg::LANES > 0) ? (POLY_LEN / dgs_pkg::LANES) : 1;
	localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

	dgs_pkg::store_t            word_store_q;
	dgs_pkg::store_t            view;
	logic [dgs_pkg::CNT_W-1:0]  count_q;
	logic [dgs_pkg::CNT_W-1:0]  cnt_nxt;
	logic [dgs_pkg::CNT_W-1:0]  size;
	logic [dgs_pkg::CNT_W-1:0]  sign_idx;
	logic [GW-1:0]              group_q;
	dgs_pkg::variant_t          variant_q;
	logic [3:0]                 shift_q;
	logic                       complete;
	logic                       last_group;
	logic                       accept;

	always_comb begin
		size     = dgs_pkg::group_size(variant_q);
		sign_idx = size - 4'd1;
		cnt_nxt  = count_q + 4'd1;
		complete = (cnt_nxt >= size);
		s_tready = !(complete && q_full);
		accept   = s_tvalid && s_tready;
		for (int i = 0; i < dgs_pkg::STORE_DEPTH; i++) begin
			view[i] = (dgs_pkg::CNT_W'(i) == count_q) ? s_tdata : word_store_q[i];
		end
		last_group       = (group_q == GW'(GROUPS - 1));
		q_push           = accept && complete;
		q_data.mag       = dgs_pkg::mag_eval(variant_q, view);
		q_data.sign      = view[sign_idx];
		q_data.shift     = shift_q;
		q_data.grp       = 2'(group_q);
		q_data.poly_last = last_group;
	end

	always_ff @(posedge clk) begin
		if (accept && count_q < dgs_pkg::CNT_W'(dgs_pkg::STORE_DEPTH)) begin
			word_store_q[count_q] <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			group_q   <= '0;
			variant_q <= dgs_pkg::NV_D1;
			shift_q   <= dgs_pkg::SHIFT_RESET;
		end else begin
			if (accept) begin
				count_q <= complete ? '0 : cnt_nxt;
				if (complete) begin
					group_q <= last_group ? '0 : group_q + GW'(1);
				end
			end
			if (cfg_we) begin
				if (cfg_addr == dgs_pkg::REG_NOISE_VARIANT) begin
					variant_q <= dgs_pkg::variant_t'(cfg_wdata[1:0]);
				end else if (cfg_addr == dgs_pkg::REG_COEFF_SHIFT) begin
					shift_q <= cfg_wdata;
				end
			end
		end
	end

endmodule

// ===== rtl/dgs_fifo.sv =====
// short queue of evaluated groups between front and back
`include "bitsliced_discrete_gaussian_sampler_assert.svh"

module dgs_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dgs_pkg::grp_rec_t push_data,
	input  logic              pop,
	output dgs_pkg::grp_rec_t pop_data,
	output logic              full,
	output logic              empty
);

	localparam int QAW = (dgs_pkg::QUEUE_DEPTH > 1) ? $clog2(dgs_pkg::QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(dgs_pkg::QUEUE_DEPTH + 1);

	dgs_pkg::grp_rec_t mem_q [dgs_pkg::QUEUE_DEPTH];
	logic [QAW-1:0]    wr_ptr_q;
	logic [QAW-1:0]    rd_ptr_q;
	logic [QCW-1:0]    count_q;

	assign full     = (count_q == QCW'(dgs_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(dgs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(dgs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	`DGS_ASSERT_IMP(a_no_push_full, push, !full || pop, "push into full queue")
	`DGS_ASSERT_IMP(a_no_pop_empty, pop, !empty, "pop from empty queue")
	`DGS_ASSERT_NXT(a_push_fills, push && !pop, !empty, "queue empty after push")

endmodule

// ===== rtl/dgs_back.sv =====
// back end: walks the 64 lanes of a group and drives the output register
`include "bitsliced_discrete_gaussian_sampler_assert.svh"

module dgs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  dgs_pkg::grp_rec_t q_data,
	output logic              q_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,
	output logic              m_tlast,
	output logic              m_tuser
);

	localparam logic [dgs_pkg::LANE_W-1:0] LAST_LANE = dgs_pkg::LANE_W'(dgs_pkg::LANES - 1);

	dgs_pkg::grp_rec_t           grp_q;
	logic                        active_q;
	logic [dgs_pkg::LANE_W-1:0]  lane_q;
	logic                        out_valid_q;
	logic [15:0]                 coeff_q;
	logic [7:0]                  index_q;
	logic                        glast_q;
	logic                        plast_q;
	logic                        advance;
	logic                        emit;
	logic                        at_last;
	logic [3:0]                  mag;
	logic [15:0]                 mag16;
	logic [15:0]                 signed16;
	logic [15:0]                 coeff;

	always_comb begin
		advance  = !out_valid_q || m_tready;
		emit     = advance && active_q;
		at_last  = (lane_q == LAST_LANE);
		q_pop    = !q_empty && (!active_q || (emit && at_last));
		mag      = {grp_q.mag[3][lane_q], grp_q.mag[2][lane_q],
		            grp_q.mag[1][lane_q], grp_q.mag[0][lane_q]};
		mag16    = {12'd0, mag};
		signed16 = grp_q.sign[lane_q] ? (16'd0 - mag16) : mag16;
		coeff    = signed16 << grp_q.shift;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			grp_q <= q_data;
		end
		if (emit) begin
			coeff_q <= coeff;
			index_q <= {grp_q.grp, lane_q};
			glast_q <= at_last;
			plast_q <= at_last && grp_q.poly_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			lane_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= active_q;
			end
			if (q_pop) begin
				active_q <= 1'b1;
				lane_q   <= '0;
			end else if (emit) begin
				if (at_last) begin
					active_q <= 1'b0;
				end
				lane_q <= lane_q + dgs_pkg::LANE_W'(1);
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {index_q, coeff_q};
	assign m_tlast  = glast_q;
	assign m_tuser  = plast_q;

	`DGS_ASSERT_IMP(a_last_lane, m_tvalid && m_tlast, m_tdata[21:16] == LAST_LANE, "tlast off lane 63")
	`DGS_ASSERT_IMP(a_poly_in_group, m_tvalid && m_tuser, m_tlast, "poly end without group end")
	`DGS_ASSERT_IMP(a_mid_group_active, m_tvalid && !m_tlast, active_q, "group dropped mid-way")

endmodule

// ===== rtl/bitsliced_discrete_gaussian_sampler.sv =====
// top level of the bit-sliced discrete gaussian sampler
// a group's first coefficient passes queue, group and output registers after its last word
// one coefficient per cycle if unstalled, 64 per group of 10 to 12 words, from the lane walk
// input words are taken every cycle while the two-entry group queue has room
// reset: counters and queue cleared, noise_variant 0, coeff_shift 6, word store left as is
module bitsliced_discrete_gaussian_sampler #(
	parameter int POLY_LEN = dgs_pkg::POLY_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [63:0]                 s_tdata,    // random_word
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,    // coefficient[15:0], coeff_index[23:16]
	output logic                        m_tlast,
	output logic                        m_tuser,    // poly_last
	input  logic                        cfg_we,
	input  logic [dgs_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [dgs_pkg::CFG_DW-1:0]  cfg_wdata
);

	dgs_pkg::grp_rec_t push_data;
	dgs_pkg::grp_rec_t pop_data;
	logic              push;
	logic              pop;
	logic              full;
	logic              empty;

	dgs_front #(
		.POLY_LEN (POLY_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.q_full    (full),
		.q_push    (push),
		.q_data    (push_data)
	);

	dgs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	dgs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (empty),
		.q_data   (pop_data),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
